### design/adsr_pkg.sv
// ----------------------------------------------------------------------------
// ADSR envelope package
// Shared types, codes, register map and the sequencer control program.
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

    // Parameter defaults
    localparam int DEFAULT_TIME_BITS           = 20;
    localparam int DEFAULT_LEVEL_FRACTION_BITS = 24;

    // Field widths
    localparam int TIME_W  = 20;
    localparam int FRAC_W  = 16;
    localparam int MODE_W  = 2;
    localparam int VEL_W   = 7;
    localparam int LEVEL_W = 16;
    localparam int PHASE_W = 3;
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 5;
    localparam int VPROD_W = 23;
    localparam int NUM_W   = 22;

    // Arithmetic constants
    localparam logic [FRAC_W-1:0]  Q15_ONE  = 16'd32768;
    localparam logic [VEL_W-1:0]   VEL_MAX  = 7'd127;
    localparam logic [NUM_W-1:0]   PEAK_DEN = 22'd4161536;  // 32768 * 127

    // Register indexes
    localparam logic [2:0] REG_ATTACK  = 3'd0;
    localparam logic [2:0] REG_DECAY   = 3'd1;
    localparam logic [2:0] REG_RELEASE = 3'd2;
    localparam logic [2:0] REG_SUSTAIN = 3'd3;
    localparam logic [2:0] REG_VSENS   = 3'd4;

    // Register reset values
    localparam logic [TIME_W-1:0] RST_ATTACK  = 20'd480;
    localparam logic [TIME_W-1:0] RST_DECAY   = 20'd4800;
    localparam logic [TIME_W-1:0] RST_RELEASE = 20'd9600;
    localparam logic [FRAC_W-1:0] RST_SUSTAIN = 16'd22938;
    localparam logic [FRAC_W-1:0] RST_VSENS   = 16'd0;

    // Input modes
    localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NOTE_ON  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NOTE_OFF = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;

    // Envelope phases
    localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;

    // Configuration registers
    typedef struct packed {
        logic [TIME_W-1:0] attack_samples;
        logic [TIME_W-1:0] decay_samples;
        logic [TIME_W-1:0] release_samples;
        logic [FRAC_W-1:0] sustain_level;
        logic [FRAC_W-1:0] velocity_sensitivity;
    } t_cfg;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        U_NOP       = 4'd0,
        U_LATCH     = 4'd1,
        U_MUL_TGT   = 4'd2,
        U_TICK      = 4'd3,
        U_MUL_VEL   = 4'd4,
        U_LOAD_PEAK = 4'd5,
        U_WR_PEAK   = 4'd6,
        U_LOAD_A    = 4'd7,
        U_WR_A      = 4'd8,
        U_LOAD_D    = 4'd9,
        U_WR_D      = 4'd10,
        U_LOAD_R    = 4'd11,
        U_WR_R      = 4'd12,
        U_NOTE_OFF  = 4'd13,
        U_EMIT      = 4'd14
    } t_uop;

    // Sequencing conditions
    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_JUMP     = 3'd1,
        C_DISPATCH = 3'd2,
        C_WAIT_DIV = 3'd3,
        C_WAIT_OUT = 3'd4
    } t_cond;

    localparam int PC_W = 4;

    typedef struct packed {
        t_uop              op;
        t_cond             cond;
        logic [PC_W-1:0]   target;
    } t_uword;

    typedef struct packed {
        t_uop op;
        logic fire;
    } t_ctrl;

    typedef struct packed {
        logic div_busy;
        logic out_full;
    } t_stat;

    // Program addresses
    localparam logic [PC_W-1:0] A_FETCH    = 4'd0;
    localparam logic [PC_W-1:0] A_TICK     = 4'd1;
    localparam logic [PC_W-1:0] A_NOTE_ON  = 4'd3;
    localparam logic [PC_W-1:0] A_WR_PEAK  = 4'd5;
    localparam logic [PC_W-1:0] A_MUL_TGT  = 4'd6;
    localparam logic [PC_W-1:0] A_WR_A     = 4'd8;
    localparam logic [PC_W-1:0] A_LOAD_D   = 4'd9;
    localparam logic [PC_W-1:0] A_WR_D     = 4'd10;
    localparam logic [PC_W-1:0] A_LOAD_R   = 4'd11;
    localparam logic [PC_W-1:0] A_NOTE_OFF = 4'd13;
    localparam logic [PC_W-1:0] A_EMIT     = 4'd14;

    // Control store
    function automatic t_uword rom(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: U_NOP, cond: C_JUMP, target: A_FETCH};
        unique case (pc)
            4'd0:    w = '{op: U_LATCH,     cond: C_DISPATCH, target: A_FETCH};
            4'd1:    w = '{op: U_MUL_TGT,   cond: C_NEXT,     target: A_FETCH};
            4'd2:    w = '{op: U_TICK,      cond: C_JUMP,     target: A_EMIT};
            4'd3:    w = '{op: U_MUL_VEL,   cond: C_NEXT,     target: A_FETCH};
            4'd4:    w = '{op: U_LOAD_PEAK, cond: C_NEXT,     target: A_FETCH};
            4'd5:    w = '{op: U_WR_PEAK,   cond: C_WAIT_DIV, target: A_MUL_TGT};
            4'd6:    w = '{op: U_MUL_TGT,   cond: C_NEXT,     target: A_FETCH};
            4'd7:    w = '{op: U_LOAD_A,    cond: C_NEXT,     target: A_FETCH};
            4'd8:    w = '{op: U_WR_A,      cond: C_WAIT_DIV, target: A_LOAD_D};
            4'd9:    w = '{op: U_LOAD_D,    cond: C_NEXT,     target: A_FETCH};
            4'd10:   w = '{op: U_WR_D,      cond: C_WAIT_DIV, target: A_LOAD_R};
            4'd11:   w = '{op: U_LOAD_R,    cond: C_NEXT,     target: A_FETCH};
            4'd12:   w = '{op: U_WR_R,      cond: C_WAIT_DIV, target: A_EMIT};
            4'd13:   w = '{op: U_NOTE_OFF,  cond: C_JUMP,     target: A_EMIT};
            4'd14:   w = '{op: U_EMIT,      cond: C_WAIT_OUT, target: A_FETCH};
            default: w = '{op: U_NOP,       cond: C_JUMP,     target: A_FETCH};
        endcase
        return w;
    endfunction

    // Entry point for each input mode
    function automatic logic [PC_W-1:0] dispatch(input logic [MODE_W-1:0] mode);
        logic [PC_W-1:0] a;
        a = A_EMIT;
        unique case (mode)
            MODE_TICK:     a = A_TICK;
            MODE_NOTE_ON:  a = A_NOTE_ON;
            MODE_NOTE_OFF: a = A_NOTE_OFF;
            MODE_UNUSED:   a = A_EMIT;
            default:       a = A_EMIT;
        endcase
        return a;
    endfunction

    // Limit a Q1.15 fraction to one
    function automatic logic [FRAC_W-1:0] clamp_q15(input logic [FRAC_W-1:0] v);
        return (v > Q15_ONE) ? Q15_ONE : v;
    endfunction

endpackage

`default_nettype wire

### design/adsr_in_if.sv
// ----------------------------------------------------------------------------
// ADSR input channel
// Valid/ready channel carrying one event: mode and velocity.
// ----------------------------------------------------------------------------
`default_nettype none

interface adsr_in_if;
    logic                         valid;
    logic                         ready;
    logic [adsr_pkg::MODE_W-1:0]  mode;
    logic [adsr_pkg::VEL_W-1:0]   velocity;

    modport source (output valid, output mode, output velocity, input ready);
    modport sink   (input valid, input mode, input velocity, output ready);
endinterface

`default_nettype wire

### design/adsr_out_if.sv
// ----------------------------------------------------------------------------
// ADSR output channel
// Valid/ready channel carrying one envelope result: level and phase.
// ----------------------------------------------------------------------------
`default_nettype none

interface adsr_out_if;
    logic                          valid;
    logic                          ready;
    logic [adsr_pkg::LEVEL_W-1:0]  level;
    logic [adsr_pkg::PHASE_W-1:0]  phase;

    modport source (output valid, output level, output phase, input ready);
    modport sink   (input valid, input level, input phase, output ready);
endinterface

`default_nettype wire

### design/adsr_envelope_generator_unit.sv
// ----------------------------------------------------------------------------
// ADSR envelope generator
// Linear attack/decay/sustain/release envelope with velocity-scaled peak.
// ----------------------------------------------------------------------------
// Each input transaction (sample tick, note on, note off) yields exactly one
// result transaction carrying the Q1.15 level and the phase after the event.
// Items are handled one at a time by a microcoded sequencer. After the
// accepting step, a sample tick runs the target multiply, the tick and the
// emit step, a note off the note-off and emit steps and an unused mode only
// the emit step, in which the result register loads. A note on runs the
// velocity multiply, the peak division, the target multiply and the attack,
// decay and release step divisions before its emit step: its peak and three
// step values each pass through one shared restoring divider, DVW bits wide,
// DVW = max(LEVEL_FRACTION_BITS + 7, max(LEVEL_FRACTION_BITS, TIME_BITS) + 2),
// that produces a single quotient bit per clock. The next transaction is
// accepted while a finished result still waits in the output register; the
// following result then stalls in its last step until that register is taken.
// Configuration is to be written through the APB port only while the block is
// idle; the block does not enforce this. Registers lie at byte offsets 0x00
// attack, 0x04 decay, 0x08 release, 0x0C sustain and 0x10 velocity sensitivity.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_envelope_generator_unit #(
    parameter int TIME_BITS           = adsr_pkg::DEFAULT_TIME_BITS,
    parameter int LEVEL_FRACTION_BITS = adsr_pkg::DEFAULT_LEVEL_FRACTION_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    adsr_in_if.sink                             i_in,
    adsr_out_if.source                          o_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [adsr_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [adsr_pkg::PDATA_W-1:0]   pwdata,
    output logic      [adsr_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready
);

    adsr_pkg::t_cfg  r_cfg;
    adsr_pkg::t_ctrl ctrl;
    adsr_pkg::t_stat stat;
    logic            wr_en;
    logic [2:0]      reg_idx;
    logic            in_ready;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[adsr_pkg::PADDR_W-1:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_samples       <= adsr_pkg::RST_ATTACK;
            r_cfg.decay_samples        <= adsr_pkg::RST_DECAY;
            r_cfg.release_samples      <= adsr_pkg::RST_RELEASE;
            r_cfg.sustain_level        <= adsr_pkg::RST_SUSTAIN;
            r_cfg.velocity_sensitivity <= adsr_pkg::RST_VSENS;
        end else if (wr_en) begin
            unique case (reg_idx)
                adsr_pkg::REG_ATTACK:
                    r_cfg.attack_samples <= pwdata[adsr_pkg::TIME_W-1:0];
                adsr_pkg::REG_DECAY:
                    r_cfg.decay_samples <= pwdata[adsr_pkg::TIME_W-1:0];
                adsr_pkg::REG_RELEASE:
                    r_cfg.release_samples <= pwdata[adsr_pkg::TIME_W-1:0];
                adsr_pkg::REG_SUSTAIN:
                    r_cfg.sustain_level <= pwdata[adsr_pkg::FRAC_W-1:0];
                adsr_pkg::REG_VSENS:
                    r_cfg.velocity_sensitivity <= pwdata[adsr_pkg::FRAC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_idx)
            adsr_pkg::REG_ATTACK:  prdata = adsr_pkg::PDATA_W'(r_cfg.attack_samples);
            adsr_pkg::REG_DECAY:   prdata = adsr_pkg::PDATA_W'(r_cfg.decay_samples);
            adsr_pkg::REG_RELEASE: prdata = adsr_pkg::PDATA_W'(r_cfg.release_samples);
            adsr_pkg::REG_SUSTAIN: prdata = adsr_pkg::PDATA_W'(r_cfg.sustain_level);
            adsr_pkg::REG_VSENS:   prdata = adsr_pkg::PDATA_W'(r_cfg.velocity_sensitivity);
            default:               prdata = '0;
        endcase
    end

    adsr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_mode  (i_in.mode),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_ctrl     (ctrl)
    );

    adsr_dpath #(
        .TIME_BITS           (TIME_BITS),
        .LEVEL_FRACTION_BITS (LEVEL_FRACTION_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_cfg       (r_cfg),
        .i_vel       (i_in.velocity),
        .i_out_ready (o_out.ready),
        .o_stat      (stat),
        .o_out_valid (o_out.valid),
        .o_level     (o_out.level),
        .o_phase     (o_out.phase)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire

### design/adsr_div.sv
// ----------------------------------------------------------------------------
// ADSR serial divider
// Restoring unsigned divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_div #(
    parameter int DVW = 31,
    parameter int DSW = 20
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [DVW-1:0] i_dividend,
    input  wire logic [DSW-1:0] i_divisor,
    output logic                o_busy,
    output logic [DVW-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(DVW + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DVW-1:0]   r_quo;
    logic [DSW-1:0]   r_rem;
    logic [DSW-1:0]   r_dsr;

    logic [DSW:0]     trial;
    logic [DSW:0]     diff;
    logic             ge;

    // Shift one dividend bit into the partial remainder and try the subtract
    always_comb begin
        trial = {r_rem, r_quo[DVW-1]};
        diff  = trial - {1'b0, r_dsr};
        ge    = (trial >= {1'b0, r_dsr});
    end

    // Control: count the iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DVW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVW-2:0], ge};
            r_rem <= ge ? diff[DSW-1:0] : trial[DSW-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### design/adsr_seq.sv
// ----------------------------------------------------------------------------
// ADSR sequencer
// Step counter over the control store, with dispatch and wait conditions.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_seq (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic [adsr_pkg::MODE_W-1:0]  i_in_mode,
    input  wire adsr_pkg::t_stat              i_stat,
    output logic                              o_in_ready,
    output adsr_pkg::t_ctrl                   o_ctrl
);

    logic [adsr_pkg::PC_W-1:0] r_pc;
    logic [adsr_pkg::PC_W-1:0] n_pc;
    adsr_pkg::t_uword          uw;
    logic                      fire;

    // Decode the current step and pick the next one
    always_comb begin
        uw   = adsr_pkg::rom(r_pc);
        n_pc = r_pc;
        fire = 1'b0;
        unique case (uw.cond)
            adsr_pkg::C_NEXT: begin
                n_pc = r_pc + adsr_pkg::PC_W'(1);
                fire = 1'b1;
            end
            adsr_pkg::C_JUMP: begin
                n_pc = uw.target;
                fire = 1'b1;
            end
            adsr_pkg::C_DISPATCH: begin
                if (i_in_valid) begin
                    n_pc = adsr_pkg::dispatch(i_in_mode);
                    fire = 1'b1;
                end
            end
            adsr_pkg::C_WAIT_DIV: begin
                if (!i_stat.div_busy) begin
                    n_pc = uw.target;
                    fire = 1'b1;
                end
            end
            adsr_pkg::C_WAIT_OUT: begin
                if (!i_stat.out_full) begin
                    n_pc = uw.target;
                    fire = 1'b1;
                end
            end
            default: begin
                n_pc = adsr_pkg::A_FETCH;
            end
        endcase
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= adsr_pkg::A_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_in_ready  = (uw.cond == adsr_pkg::C_DISPATCH);
    assign o_ctrl.op   = uw.op;
    assign o_ctrl.fire = fire;

endmodule

`default_nettype wire

### design/adsr_dpath.sv
// ----------------------------------------------------------------------------
// ADSR datapath
// Envelope state, step arithmetic, serial divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_dpath #(
    parameter int TIME_BITS           = adsr_pkg::DEFAULT_TIME_BITS,
    parameter int LEVEL_FRACTION_BITS = adsr_pkg::DEFAULT_LEVEL_FRACTION_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire adsr_pkg::t_ctrl               i_ctrl,
    input  wire adsr_pkg::t_cfg                i_cfg,
    input  wire logic [adsr_pkg::VEL_W-1:0]    i_vel,
    input  wire logic                          i_out_ready,
    output adsr_pkg::t_stat                    o_stat,
    output logic                               o_out_valid,
    output logic [adsr_pkg::LEVEL_W-1:0]       o_level,
    output logic [adsr_pkg::PHASE_W-1:0]       o_phase
);

    localparam int F    = LEVEL_FRACTION_BITS;
    localparam int TB   = TIME_BITS;
    localparam int PW   = F + 1;            // peak, target and step width
    localparam int AW   = F + 2;            // amplitude, room for one attack add
    localparam int SH   = F - 15;           // internal to Q1.15 shift
    localparam int PDW  = F + 7;            // peak dividend width
    localparam int SDW  = ((F > TB) ? F : TB) + 2;
    localparam int DVW  = (PDW > SDW) ? PDW : SDW;
    localparam int DSW  = TB;
    localparam int MW   = PW + adsr_pkg::FRAC_W;
    localparam int LSW  = AW - SH;

    // Envelope state
    logic [adsr_pkg::PHASE_W-1:0] r_phase;
    logic [AW-1:0]                r_amp;
    logic [PW-1:0]                r_peak;
    logic [PW-1:0]                r_astep;
    logic [PW-1:0]                r_dstep;
    logic [PW-1:0]                r_rstep;

    // Working registers
    logic [adsr_pkg::VEL_W-1:0]   r_vel;
    logic [PW-1:0]                r_tgt;
    logic [adsr_pkg::VPROD_W-1:0] r_vprod;
    logic [PW-1:0]                r_dist;
    logic                         r_tzero;

    // Result register
    logic                         r_out_valid;
    logic [adsr_pkg::LEVEL_W-1:0] r_level;
    logic [adsr_pkg::PHASE_W-1:0] r_out_phase;

    logic                         fire;
    adsr_pkg::t_uop               op;
    logic [adsr_pkg::FRAC_W-1:0]  sus_c;
    logic [adsr_pkg::FRAC_W-1:0]  vs_c;
    logic [MW-1:0]                tgt_prod;
    logic [adsr_pkg::NUM_W-1:0]   num;

    logic                         div_start;
    logic [DVW-1:0]               div_dvd;
    logic [DSW-1:0]               div_dsr;
    logic                         div_busy;
    logic [DVW-1:0]               div_quo;

    logic [PW-1:0]                ld_dist;
    logic [TB-1:0]                ld_ticks;
    logic [PW-1:0]                step_res;

    logic [AW-1:0]                atk_sum;
    logic [AW-1:0]                tgt_ext;
    logic [AW-1:0]                dstep_ext;
    logic [AW-1:0]                rstep_ext;
    logic [AW-1:0]                peak_ext;
    logic [AW-1:0]                t_amp;
    logic [adsr_pkg::PHASE_W-1:0] t_phase;

    logic [LSW-1:0]               lvl_sh;
    logic [adsr_pkg::LEVEL_W-1:0] lvl_c;

    assign fire  = i_ctrl.fire;
    assign op    = i_ctrl.op;
    assign sus_c = adsr_pkg::clamp_q15(i_cfg.sustain_level);
    assign vs_c  = adsr_pkg::clamp_q15(i_cfg.velocity_sensitivity);

    // Sustain target product and peak numerator
    assign tgt_prod = MW'(r_peak) * MW'(sus_c);
    assign num      = adsr_pkg::PEAK_DEN - r_vprod[adsr_pkg::NUM_W-1:0];

    // Select distance and length for a step division
    always_comb begin
        ld_dist  = r_peak;
        ld_ticks = TB'(i_cfg.attack_samples);
        unique case (op)
            adsr_pkg::U_LOAD_D: begin
                ld_dist  = r_peak - r_tgt;
                ld_ticks = TB'(i_cfg.decay_samples);
            end
            adsr_pkg::U_LOAD_R: begin
                ld_dist  = r_tgt;
                ld_ticks = TB'(i_cfg.release_samples);
            end
            default: begin
                ld_dist  = r_peak;
                ld_ticks = TB'(i_cfg.attack_samples);
            end
        endcase
    end

    // Divider operands: rounded-up step or the velocity-scaled peak
    always_comb begin
        div_start = fire && (op == adsr_pkg::U_LOAD_PEAK || op == adsr_pkg::U_LOAD_A ||
                             op == adsr_pkg::U_LOAD_D || op == adsr_pkg::U_LOAD_R);
        if (op == adsr_pkg::U_LOAD_PEAK) begin
            div_dvd = DVW'(num) << SH;
            div_dsr = DSW'(adsr_pkg::VEL_MAX);
        end else begin
            div_dvd = DVW'(ld_dist) + DVW'(ld_ticks) - DVW'(1);
            div_dsr = ld_ticks;
        end
    end

    adsr_div #(
        .DVW (DVW),
        .DSW (DSW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    // A zero length takes the whole distance in one tick
    assign step_res = r_tzero ? r_dist : div_quo[PW-1:0];

    // Advance the envelope by one sample tick
    always_comb begin
        tgt_ext   = AW'(r_tgt);
        dstep_ext = AW'(r_dstep);
        rstep_ext = AW'(r_rstep);
        peak_ext  = AW'(r_peak);
        atk_sum   = r_amp + AW'(r_astep);
        t_amp     = r_amp;
        t_phase   = r_phase;
        unique case (r_phase)
            adsr_pkg::PH_ATTACK: begin
                if (atk_sum >= peak_ext) begin
                    t_amp   = peak_ext;
                    t_phase = adsr_pkg::PH_DECAY;
                end else begin
                    t_amp = atk_sum;
                end
            end
            adsr_pkg::PH_DECAY: begin
                if (r_amp <= tgt_ext || (r_amp - tgt_ext) <= dstep_ext) begin
                    t_amp   = tgt_ext;
                    t_phase = adsr_pkg::PH_SUSTAIN;
                end else begin
                    t_amp = r_amp - dstep_ext;
                end
            end
            adsr_pkg::PH_SUSTAIN: begin
                t_amp = tgt_ext;
            end
            adsr_pkg::PH_RELEASE: begin
                if (r_amp <= rstep_ext) begin
                    t_amp   = '0;
                    t_phase = adsr_pkg::PH_IDLE;
                end else begin
                    t_amp = r_amp - rstep_ext;
                end
            end
            default: begin
                t_amp   = '0;
                t_phase = adsr_pkg::PH_IDLE;
            end
        endcase
    end

    // Envelope state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= adsr_pkg::PH_IDLE;
            r_amp   <= '0;
            r_peak  <= PW'(1) << F;
            r_astep <= '0;
            r_dstep <= '0;
            r_rstep <= '0;
        end else if (fire) begin
            unique case (op)
                adsr_pkg::U_TICK: begin
                    r_amp   <= t_amp;
                    r_phase <= t_phase;
                end
                adsr_pkg::U_WR_PEAK: begin
                    r_peak  <= div_quo[PW-1:0];
                    r_amp   <= '0;
                    r_phase <= adsr_pkg::PH_ATTACK;
                end
                adsr_pkg::U_WR_A: begin
                    r_astep <= step_res;
                end
                adsr_pkg::U_WR_D: begin
                    r_dstep <= step_res;
                end
                adsr_pkg::U_WR_R: begin
                    r_rstep <= (r_tgt == '0) ? r_peak : step_res;
                end
                adsr_pkg::U_NOTE_OFF: begin
                    if (r_phase != adsr_pkg::PH_IDLE) begin
                        r_phase <= adsr_pkg::PH_RELEASE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers: latch velocity, products and division operands
    always_ff @(posedge i_clk) begin
        if (fire) begin
            unique case (op)
                adsr_pkg::U_LATCH: begin
                    r_vel <= i_vel;
                end
                adsr_pkg::U_MUL_TGT: begin
                    r_tgt <= tgt_prod[PW+14:15];
                end
                adsr_pkg::U_MUL_VEL: begin
                    r_vprod <= adsr_pkg::VPROD_W'(vs_c) *
                               adsr_pkg::VPROD_W'(adsr_pkg::VEL_MAX - r_vel);
                end
                adsr_pkg::U_LOAD_A, adsr_pkg::U_LOAD_D, adsr_pkg::U_LOAD_R: begin
                    r_dist  <= ld_dist;
                    r_tzero <= (ld_ticks == '0);
                end
                default: begin
                end
            endcase
        end
    end

    // Convert to Q1.15 and clamp to one
    assign lvl_sh = r_amp[AW-1:SH];
    assign lvl_c  = (lvl_sh > LSW'(adsr_pkg::Q15_ONE)) ? adsr_pkg::Q15_ONE
                                                       : lvl_sh[adsr_pkg::LEVEL_W-1:0];

    // Result register: load on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && op == adsr_pkg::U_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && op == adsr_pkg::U_EMIT) begin
            r_level     <= lvl_c;
            r_out_phase <= r_phase;
        end
    end

    assign o_stat.div_busy = div_busy;
    assign o_stat.out_full = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_level         = r_level;
    assign o_phase         = r_out_phase;

endmodule

`default_nettype wire
